/* hw/rtl/scdkf_pkg.sv */
// ----------------------------------------------------------------------------
// scdkf_pkg: shared types and constants for the scan code decoder key FIFO
//
// Word formats of both channels, register indexes, scan code constants and
// the scan-code-set-1 to ASCII table.
// ----------------------------------------------------------------------------
package scdkf_pkg;

  // Default number of entries in the key store; it holds one key fewer.
  localparam int FIFO_DEPTH_DEF = 32;

  // Width of one stored key and of each arrow code register.
  localparam int KEY_W = 16;

  // Width of the configuration register index and data.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Input word kinds.
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_UP    = 3'd0,
    CFG_DOWN  = 3'd1,
    CFG_LEFT  = 3'd2,
    CFG_RIGHT = 3'd3
  } cfg_idx_t;

  // Reset values of the arrow code registers.
  localparam logic [KEY_W-1:0] UP_CODE_RST    = 16'd256;
  localparam logic [KEY_W-1:0] DOWN_CODE_RST  = 16'd257;
  localparam logic [KEY_W-1:0] LEFT_CODE_RST  = 16'd258;
  localparam logic [KEY_W-1:0] RIGHT_CODE_RST = 16'd259;

  // Scan code set 1 constants.
  localparam logic [7:0] SC_EXTENDED = 8'hE0;
  localparam logic [7:0] SC_UP       = 8'h48;
  localparam logic [7:0] SC_DOWN     = 8'h50;
  localparam logic [7:0] SC_LEFT     = 8'h4B;
  localparam logic [7:0] SC_RIGHT    = 8'h4D;
  localparam int         SC_BREAK_BIT = 7;

  // Input word: a scan code byte or a pop request.
  typedef struct packed {
    logic       kind;
    logic [7:0] scan_byte;
  } in_word_t;

  // Result word.
  typedef struct packed {
    logic             key_valid;
    logic [KEY_W-1:0] key_value;
    logic             dropped;
  } out_word_t;

  // Arrow codes programmed through the configuration port.
  typedef struct packed {
    logic [KEY_W-1:0] up;
    logic [KEY_W-1:0] down;
    logic [KEY_W-1:0] left;
    logic [KEY_W-1:0] right;
  } arrow_codes_t;

  // Decoder result handed to the FIFO control.
  typedef struct packed {
    logic             key_ok;
    logic             ext_nxt;
    logic [KEY_W-1:0] key;
  } dec_t;

  // Scan code set 1 make code to ASCII; unlisted codes give zero.
  function automatic logic [7:0] ascii_rom(input logic [6:0] code);
    logic [7:0] val;
    case (code)
      7'd1:    val = 8'h1B;
      7'd2:    val = 8'h31;
      7'd3:    val = 8'h32;
      7'd4:    val = 8'h33;
      7'd5:    val = 8'h34;
      7'd6:    val = 8'h35;
      7'd7:    val = 8'h36;
      7'd8:    val = 8'h37;
      7'd9:    val = 8'h38;
      7'd10:   val = 8'h39;
      7'd11:   val = 8'h30;
      7'd12:   val = 8'h2D;
      7'd13:   val = 8'h3D;
      7'd14:   val = 8'h08;
      7'd15:   val = 8'h09;
      7'd16:   val = 8'h71;
      7'd17:   val = 8'h77;
      7'd18:   val = 8'h65;
      7'd19:   val = 8'h72;
      7'd20:   val = 8'h74;
      7'd21:   val = 8'h79;
      7'd22:   val = 8'h75;
      7'd23:   val = 8'h69;
      7'd24:   val = 8'h6F;
      7'd25:   val = 8'h70;
      7'd26:   val = 8'h5B;
      7'd27:   val = 8'h5D;
      7'd28:   val = 8'h0A;
      7'd30:   val = 8'h61;
      7'd31:   val = 8'h73;
      7'd32:   val = 8'h64;
      7'd33:   val = 8'h66;
      7'd34:   val = 8'h67;
      7'd35:   val = 8'h68;
      7'd36:   val = 8'h6A;
      7'd37:   val = 8'h6B;
      7'd38:   val = 8'h6C;
      7'd39:   val = 8'h3B;
      7'd40:   val = 8'h27;
      7'd41:   val = 8'h60;
      7'd43:   val = 8'h5C;
      7'd44:   val = 8'h7A;
      7'd45:   val = 8'h78;
      7'd46:   val = 8'h63;
      7'd47:   val = 8'h76;
      7'd48:   val = 8'h62;
      7'd49:   val = 8'h6E;
      7'd50:   val = 8'h6D;
      7'd51:   val = 8'h2C;
      7'd52:   val = 8'h2E;
      7'd53:   val = 8'h2F;
      7'd55:   val = 8'h2A;
      7'd57:   val = 8'h20;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

/* hw/rtl/scdkf_ram.sv */
// ----------------------------------------------------------------------------
// scdkf_ram: generic single-port-write, single-port-read RAM
//
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module scdkf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/scdkf_decode.sv */
// ----------------------------------------------------------------------------
// scdkf_decode: scan code set 1 byte decoder
//
// Tracks the extended prefix and turns one byte into a key, if any.
// ----------------------------------------------------------------------------
module scdkf_decode (
  input  logic                    ext_pending,
  input  logic [7:0]              scan_byte,
  input  scdkf_pkg::arrow_codes_t codes,
  output scdkf_pkg::dec_t         dec
);

  always_comb begin
    dec = '0;
    dec.ext_nxt = 1'b0;
    if (scan_byte == scdkf_pkg::SC_EXTENDED) begin
      // Prefix byte arms the extended flag and yields nothing.
      dec.ext_nxt = 1'b1;
    end else if (ext_pending) begin
      // Byte after the prefix: only the four arrow make codes give a key.
      case (scan_byte)
        scdkf_pkg::SC_UP: begin
          dec.key_ok = 1'b1;
          dec.key    = codes.up;
        end
        scdkf_pkg::SC_DOWN: begin
          dec.key_ok = 1'b1;
          dec.key    = codes.down;
        end
        scdkf_pkg::SC_LEFT: begin
          dec.key_ok = 1'b1;
          dec.key    = codes.left;
        end
        scdkf_pkg::SC_RIGHT: begin
          dec.key_ok = 1'b1;
          dec.key    = codes.right;
        end
        default: begin
          dec.key_ok = 1'b0;
        end
      endcase
    end else if (!scan_byte[scdkf_pkg::SC_BREAK_BIT]) begin
      // Plain make code; break codes are ignored.
      dec.key_ok = 1'b1;
      dec.key    = {{(scdkf_pkg::KEY_W-8){1'b0}}, scdkf_pkg::ascii_rom(scan_byte[6:0])};
    end
  end

endmodule

/* hw/rtl/scancode_decoder_key_fifo.sv */
// ----------------------------------------------------------------------------
// scancode_decoder_key_fifo: scan code set 1 decoder with a key FIFO
//
// Decodes keyboard bytes into keys and queues them in a RAM-based ring FIFO.
// ----------------------------------------------------------------------------
// Each input word is either a scan code byte or a request to pop one key, and
// each word gives exactly one result word. Byte words and pops on an empty
// FIFO are answered from the idle state; a pop that returns a key passes
// through a read state, as the key store is a synchronous RAM with registered
// read data and the block waits for that read before taking the next word.
// The FIFO holds FIFO_DEPTH-1 keys; a key decoded while it is full is
// discarded and the result word reports it as dropped. The arrow codes are
// to be written through the configuration port while the block is idle; the
// block does not enforce this. The key store needs no clearing after reset.
module scancode_decoder_key_fifo #(
  parameter int FIFO_DEPTH = scdkf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input words
  input  logic                             in_valid,
  output logic                             in_ready,
  input  scdkf_pkg::in_word_t              in_data,
  // Result words
  output logic                             out_valid,
  input  logic                             out_ready,
  output scdkf_pkg::out_word_t             out_data,
  // Configuration port
  input  logic                             cfg_wr_en,
  input  logic [scdkf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [scdkf_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            ext_r, ext_nxt;
  logic [PTR_W-1:0]                wptr_r, wptr_nxt;
  logic [PTR_W-1:0]                rptr_r, rptr_nxt;
  logic                            out_valid_r, out_valid_nxt;
  scdkf_pkg::out_word_t            out_data_r, out_data_nxt;
  scdkf_pkg::arrow_codes_t         codes_r;

  scdkf_pkg::dec_t                 dec;
  logic                            accept;
  logic [PTR_W-1:0]                wptr_inc;
  logic [PTR_W-1:0]                rptr_inc;
  logic                            fifo_full;
  logic                            fifo_empty;
  logic                            ram_wr_en;
  logic [scdkf_pkg::KEY_W-1:0]     ram_rd_data;

  // Arrow code registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.up    <= scdkf_pkg::UP_CODE_RST;
      codes_r.down  <= scdkf_pkg::DOWN_CODE_RST;
      codes_r.left  <= scdkf_pkg::LEFT_CODE_RST;
      codes_r.right <= scdkf_pkg::RIGHT_CODE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx)
        scdkf_pkg::CFG_UP:    codes_r.up    <= cfg_wdata;
        scdkf_pkg::CFG_DOWN:  codes_r.down  <= cfg_wdata;
        scdkf_pkg::CFG_LEFT:  codes_r.left  <= cfg_wdata;
        scdkf_pkg::CFG_RIGHT: codes_r.right <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Byte decoder.
  scdkf_decode u_decode (
    .ext_pending (ext_r),
    .scan_byte   (in_data.scan_byte),
    .codes       (codes_r),
    .dec         (dec)
  );

  // Ring pointer arithmetic; the depth need not be a power of two.
  assign wptr_inc   = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
  assign rptr_inc   = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
  assign fifo_full  = (wptr_inc == rptr_r);
  assign fifo_empty = (wptr_r == rptr_r);

  // A new word is taken only when idle and the result register can take it.
  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // Next-state logic for the pointers, the prefix flag and the result word.
  always_comb begin
    state_nxt     = state_r;
    ext_nxt       = ext_r;
    wptr_nxt      = wptr_r;
    rptr_nxt      = rptr_r;
    ram_wr_en     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          out_data_nxt = '0;
          if (in_data.kind == scdkf_pkg::KIND_BYTE) begin
            out_valid_nxt = 1'b1;
            ext_nxt       = dec.ext_nxt;
            if (dec.key_ok) begin
              if (fifo_full) begin
                out_data_nxt.dropped = 1'b1;
              end else begin
                ram_wr_en = 1'b1;
                wptr_nxt  = wptr_inc;
              end
            end
          end else if (fifo_empty) begin
            // Pop on an empty FIFO answers at once with an empty word.
            out_valid_nxt = 1'b1;
          end else begin
            // The RAM reads the head entry at this edge.
            rptr_nxt  = rptr_inc;
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        out_valid_nxt          = 1'b1;
        out_data_nxt           = '0;
        out_data_nxt.key_valid = 1'b1;
        out_data_nxt.key_value = ram_rd_data;
        state_nxt              = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State, pointers and the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ext_r       <= 1'b0;
      wptr_r      <= '0;
      rptr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ext_r       <= ext_nxt;
      wptr_r      <= wptr_nxt;
      rptr_r      <= rptr_nxt;
      out_valid_r <= out_valid_nxt;
      out_data_r  <= out_data_nxt;
    end
  end

  // Key store; the read port always looks at the head of the FIFO.
  scdkf_ram #(
    .WIDTH (scdkf_pkg::KEY_W),
    .DEPTH (FIFO_DEPTH)
  ) u_key_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (wptr_r),
    .wr_data (dec.key),
    .rd_addr (rptr_r),
    .rd_data (ram_rd_data)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* hw/rtl/scdkf_checker.sv */
// ----------------------------------------------------------------------------
// scdkf_port_checker: port-level checks for the scan code decoder key FIFO
//
// Watches the top-level ports and flags result words that break the rules.
// ----------------------------------------------------------------------------
module scdkf_port_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input scdkf_pkg::out_word_t out_data
);

  // A stalled result word stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result word changed or vanished while stalled");

  // No new word is taken while the result register is blocked.
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input word taken while result register is blocked");

  // A word that returns a key never also reports a dropped key.
  a_pop_not_dropped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.key_valid |-> !out_data.dropped)
    else $error("popped key word also flagged as dropped");

  // Without a key the key value is zero.
  a_empty_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.key_valid |-> out_data.key_value == '0)
    else $error("nonzero key value in a word without a key");

endmodule

bind scancode_decoder_key_fifo scdkf_port_checker u_scdkf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
